FILE: sv/sld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants of the sync/length/XOR deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int MAX_FRAME_DEF = 64;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h5A;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA5;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_LEN_ERR = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_SYNC2  = 5'b00010,
        PH_LEN_HI = 5'b00100,
        PH_LEN_LO = 5'b01000,
        PH_BODY   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } t_beat;

    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_res;

    typedef struct packed {
        logic                 vld;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    data;
    } t_cfg_wr;

endpackage : sld_pkg
`default_nettype wire

FILE: sv/sld_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_in_stage
// Input register: captures one received byte per beat.
// ----------------------------------------------------------------------------
module sld_in_stage
    import sld_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic              i_advance,
    output t_beat                  o_beat
);

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              n_vld;
    logic              w_fire;

    assign o_in_ready = !r_vld || i_advance;
    assign w_fire     = i_in_valid && o_in_ready;

    always_comb begin
        n_vld = r_vld;
        if (w_fire) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_beat.vld  = r_vld;
    assign o_beat.data = r_byte;

endmodule : sld_in_stage
`default_nettype wire

FILE: sv/sld_parse.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_parse
// Frame parser: sync hunt, length check, payload count and XOR checksum.
// ----------------------------------------------------------------------------
module sld_parse
    import sld_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg_wr i_cfg,
    input  wire t_beat   i_beat,
    input  wire logic    i_advance,
    output t_res         o_res
);

    localparam int CNT_W = $clog2(MAX_FRAME);
    localparam logic [15:0] LEN_MAX = 16'(MAX_FRAME - 4);

    t_phase            r_phase,  n_phase;
    logic [BYTE_W-1:0] r_sync1;
    logic [BYTE_W-1:0] r_sync2;
    logic [BYTE_W-1:0] r_xor,    n_xor;
    logic [BYTE_W-1:0] r_len_hi, n_len_hi;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic [15:0]       w_len;
    logic [BYTE_W-1:0] w_b;
    logic              w_fire;

    assign w_fire = i_beat.vld && i_advance;
    assign w_b    = i_beat.data;
    assign w_len  = {r_len_hi, w_b};

    always_comb begin
        n_phase    = r_phase;
        n_xor      = r_xor;
        n_len_hi   = r_len_hi;
        n_cnt      = r_cnt;
        o_res.vld  = 1'b0;
        o_res.kind = KIND_PAYLOAD;
        o_res.data = w_b;
        if (w_fire) begin
            case (r_phase)
                PH_HUNT: begin
                    if (w_b == r_sync1) begin
                        n_xor   = w_b;
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (w_b == r_sync2) begin
                        n_xor   = r_xor ^ w_b;
                        n_phase = PH_LEN_HI;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN_HI: begin
                    if (r_sync1 == r_sync2) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_len_hi = w_b;
                        n_xor    = r_xor ^ w_b;
                        n_phase  = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    if (w_len == 16'd0 || w_len > LEN_MAX) begin
                        o_res.vld  = 1'b1;
                        o_res.kind = KIND_LEN_ERR;
                        n_phase    = PH_HUNT;
                    end else begin
                        n_xor   = r_xor ^ w_b;
                        n_cnt   = CNT_W'(w_len - 16'd1);
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_res.vld = 1'b1;
                    if (r_cnt != '0) begin
                        o_res.kind = KIND_PAYLOAD;
                        n_xor      = r_xor ^ w_b;
                        n_cnt      = r_cnt - CNT_W'(1);
                    end else begin
                        o_res.kind = (r_xor == w_b) ? KIND_GOOD : KIND_BAD;
                        n_xor      = '0;
                        n_phase    = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sync1 <= SYNC_FIRST_RST;
            r_sync2 <= SYNC_SECOND_RST;
        end else begin
            r_phase <= n_phase;
            if (i_cfg.vld && i_cfg.idx == CFG_SYNC_FIRST) begin
                r_sync1 <= i_cfg.data;
            end
            if (i_cfg.vld && i_cfg.idx == CFG_SYNC_SECOND) begin
                r_sync2 <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xor    <= n_xor;
        r_len_hi <= n_len_hi;
        r_cnt    <= n_cnt;
    end

endmodule : sld_parse
`default_nettype wire

FILE: sv/sld_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module sld_out_stage
    import sld_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_res              i_res,
    output logic                   o_advance,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_kind,
    output logic [BYTE_W-1:0]      o_data_byte
);

    logic              r_vld;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_data;

    assign o_advance = !r_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_advance) begin
            r_vld <= i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res.vld) begin
            r_kind <= i_res.kind;
            r_data <= i_res.data;
        end
    end

    assign o_out_valid = r_vld;
    assign o_kind      = r_kind;
    assign o_data_byte = r_data;

endmodule : sld_out_stage
`default_nettype wire

FILE: sv/sync_length_xor_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_xor_deframer_unit
// Receive deframer: sync pair, 16-bit length, payload, XOR checksum.
// ----------------------------------------------------------------------------
// channel | dir | handshake               | payload
// in      | in  | i_in_valid / o_in_ready | i_rx_byte
// out     | out | o_out_valid/ i_out_ready| o_kind, o_data_byte
// cfg     | in  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// One byte per cycle while the result register is not stalled; a result passes
// through the input register and then the result register before it shows.
// Synchronous active-low reset clears both stages and the parser phase and
// loads the sync registers with 0x5A and 0xA5; no clearing pass.
// A stalled result register stalls the parser; the input register still takes
// a byte while it is empty.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer_unit
    import sld_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_kind,
    output logic [BYTE_W-1:0]         o_data_byte,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data
);

    t_beat   w_beat;
    t_res    w_res;
    t_cfg_wr w_cfg;
    logic    w_advance;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.vld   = i_cfg_valid;
    assign w_cfg.idx   = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    sld_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_advance  (w_advance),
        .o_beat     (w_beat)
    );

    sld_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_beat    (w_beat),
        .i_advance (w_advance),
        .o_res     (w_res)
    );

    sld_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .o_advance   (w_advance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte)
    );

endmodule : sync_length_xor_deframer_unit
`default_nettype wire

FILE: sv/sld_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sld_checker
    import sld_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [1:0]           o_kind,
    input wire logic [BYTE_W-1:0]    o_data_byte,
    input wire logic                 o_cfg_ready
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_in_stall_only_on_out_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while result side is free");

    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_kind) && $stable(o_data_byte)))
        else $error("stalled result changed");

endmodule : sld_checker

bind sync_length_xor_deframer_unit sld_checker u_sld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_data_byte (o_data_byte),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire

FILE: dv/deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches the byte, result and register channels of the deframer, tracks
// the frame parse of every accepted byte on its own copy of the sync
// registers and compares each accepted result, in order, with the expected
// frame events.
// ----------------------------------------------------------------------------
module deframe_checker
    import sld_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [1:0]           i_kind,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_bytes_in,
    output int                   o_payload_beats,
    output int                   o_frame_ends,
    output int                   o_len_errors
);

    localparam logic [6:0] POS_HUNT   = 7'd0;
    localparam logic [6:0] POS_SYNC2  = 7'd1;
    localparam logic [6:0] POS_LEN_HI = 7'd2;
    localparam logic [6:0] POS_LEN_LO = 7'd3;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_frame_event;

    t_frame_event      expected_events[$];
    logic [BYTE_W-1:0] sync_a;
    logic [BYTE_W-1:0] sync_b;
    logic [6:0]        hunt_pos;
    logic [15:0]       frame_len;
    logic [BYTE_W-1:0] xor_acc;
    int                mismatches;
    int                bytes_seen;
    int                payload_seen;
    int                ends_seen;
    int                len_err_seen;

    function automatic void note_event(input t_kind k, input logic [BYTE_W-1:0] d);
        t_frame_event ev;
        ev.kind = k;
        ev.data = d;
        expected_events.push_back(ev);
    endfunction

    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        case (hunt_pos)
            POS_HUNT: begin
                if (b == sync_a) begin
                    xor_acc  = b;
                    hunt_pos = POS_SYNC2;
                end
            end
            POS_SYNC2: begin
                if (b == sync_b) begin
                    xor_acc  = xor_acc ^ b;
                    hunt_pos = POS_LEN_HI;
                end else begin
                    hunt_pos = POS_HUNT;
                end
            end
            POS_LEN_HI: begin
                if (sync_a == sync_b) begin
                    hunt_pos = POS_HUNT;
                end else begin
                    frame_len = {b, 8'h00};
                    xor_acc   = xor_acc ^ b;
                    hunt_pos  = POS_LEN_LO;
                end
            end
            POS_LEN_LO: begin
                frame_len[7:0] = b;
                if (frame_len == 16'd0 || int'(frame_len) > MAX_FRAME - 4) begin
                    hunt_pos = POS_HUNT;
                    note_event(KIND_LEN_ERR, b);
                end else begin
                    xor_acc  = xor_acc ^ b;
                    hunt_pos = hunt_pos + 7'd1;
                end
            end
            default: begin
                if (int'(hunt_pos) < int'(frame_len) + 3) begin
                    xor_acc  = xor_acc ^ b;
                    hunt_pos = hunt_pos + 7'd1;
                    note_event(KIND_PAYLOAD, b);
                end else begin
                    note_event((xor_acc == b) ? KIND_GOOD : KIND_BAD, b);
                    hunt_pos = POS_HUNT;
                    xor_acc  = '0;
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frame_event want;
        if (!i_rst_n) begin
            expected_events.delete();
            sync_a       = SYNC_FIRST_RST;
            sync_b       = SYNC_SECOND_RST;
            hunt_pos     = POS_HUNT;
            frame_len    = '0;
            xor_acc      = '0;
            mismatches   = 0;
            bytes_seen   = 0;
            payload_seen = 0;
            ends_seen    = 0;
            len_err_seen = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result beat: kind %0d data_byte 0x%02h",
                           i_kind, i_data_byte);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    if (i_kind !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, i_kind);
                        mismatches++;
                    end
                    if (i_data_byte !== want.data) begin
                        $error("data_byte: expected 0x%02h, actual 0x%02h",
                               want.data, i_data_byte);
                        mismatches++;
                    end
                    case (want.kind)
                        KIND_PAYLOAD: payload_seen++;
                        KIND_LEN_ERR: len_err_seen++;
                        default:      ends_seen++;
                    endcase
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_rx_byte);
                bytes_seen++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_SYNC_FIRST) begin
                    sync_a = i_cfg_data;
                end else if (i_cfg_index == CFG_SYNC_SECOND) begin
                    sync_b = i_cfg_data;
                end
            end
        end
        o_fail_count    <= mismatches;
        o_pending       <= expected_events.size();
        o_bytes_in      <= bytes_seen;
        o_payload_beats <= payload_seen;
        o_frame_ends    <= ends_seen;
        o_len_errors    <= len_err_seen;
    end

endmodule : deframe_checker

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives received bytes and sync register writes into the deframer with
// random idle gaps and result back-pressure, including one long hold-off,
// across several sync settings; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top
    import sld_pkg::*;
;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_LEN      = MAX_FRAME_DEF - 4;
    localparam int OPENING_LEN  = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_TOP = '1;

    // len 1 good, len 3 with 00/FF good, len 1 bad, second sync miss, len 0, len 61
    localparam logic [OPENING_LEN*BYTE_W-1:0] OPENING = {
        8'h5A, 8'hA5, 8'h00, 8'h01, 8'hFE,
        8'h5A, 8'hA5, 8'h00, 8'h03, 8'h00, 8'hFF, 8'h03,
        8'h5A, 8'hA5, 8'h00, 8'h01, 8'h01,
        8'h5A, 8'h5A, 8'hA5,
        8'h5A, 8'hA5, 8'h00, 8'h00,
        8'h5A, 8'hA5, 8'h00, 8'h3D
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           kind;
    logic [BYTE_W-1:0]    data_byte;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    int                   fail_count;
    int                   pending;
    int                   bytes_in;
    int                   payload_beats;
    int                   frame_ends;
    int                   len_errors;

    logic [BYTE_W-1:0]    cur_first;
    logic [BYTE_W-1:0]    cur_second;
    bit                   quiet;
    int                   holds_requested;
    int                   holds_served;
    int                   framed_bytes;
    int                   settings_used;
    int                   cycle_count;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sync_length_xor_deframer_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_rx_byte   (rx_byte),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_kind      (kind),
        .o_data_byte (data_byte),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    deframe_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_kind          (kind),
        .i_data_byte     (data_byte),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_in      (bytes_in),
        .o_payload_beats (payload_beats),
        .o_frame_ends    (frame_ends),
        .o_len_errors    (len_errors)
    );

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!quiet && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // stop after the length bytes when the length is out of range; cut_at > 0 truncates
    task automatic send_frame(input logic [15:0] len, input bit bad_sum, input int cut_at);
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] b;
        int                n;
        chk = cur_first ^ cur_second ^ len[15:8] ^ len[7:0];
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        framed_bytes += 4;
        if (len == 16'd0 || int'(len) > MAX_LEN) return;
        for (n = 1; n < int'(len); n++) begin
            if (n == cut_at) return;
            b   = BYTE_W'($urandom_range(0, 255));
            chk = chk ^ b;
            send_byte(b);
            framed_bytes++;
        end
        send_byte(bad_sum ? chk ^ BYTE_W'($urandom_range(1, 255)) : chk);
        framed_bytes++;
    endtask

    task automatic random_traffic(input int budget);
        int          stop_at;
        int          pick;
        int          n;
        logic [15:0] len;
        stop_at = framed_bytes + budget;
        while (framed_bytes < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                case ($urandom_range(0, 9))
                    0:       len = 16'(MAX_LEN - $urandom_range(0, 1));
                    1, 2:    len = 16'($urandom_range(9, MAX_LEN));
                    default: len = 16'($urandom_range(1, 8));
                endcase
                send_frame(len, $urandom_range(0, 99) < 15, 0);
            end else if (pick < 75) begin
                case ($urandom_range(0, 4))
                    0:       len = 16'd0;
                    1:       len = 16'(MAX_LEN + 1);
                    2:       len = 16'hFFFF;
                    3:       len = 16'($urandom_range(MAX_LEN + 1, 255));
                    default: len = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
                endcase
                send_frame(len, 1'b0, 0);
            end else if (pick < 83) begin
                for (n = $urandom_range(1, 4); n > 0; n--) begin
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
            end else if (pick < 91) begin
                send_byte(cur_first);
                send_byte(cur_second ^ (8'h01 << $urandom_range(0, 7)));
                framed_bytes += 2;
            end else begin
                len = 16'($urandom_range(4, MAX_LEN));
                send_frame(len, 1'b0, $urandom_range(1, int'(len) - 1));
            end
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_syncs(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                             input bit with_unused, input logic [CFG_IDX_W-1:0] unused_idx);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (with_unused) begin
            cfg_index <= unused_idx;
            cfg_data  <= ~first;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        cur_first  = first;
        cur_second = second;
        settings_used++;
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_count, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : result_sink
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (holds_served < holds_requested) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end else if (!quiet && $urandom_range(0, 99) < 30) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] v;
        int                i;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        rx_byte         <= '0;
        out_ready       <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= CFG_SYNC_FIRST;
        cfg_data        <= '0;
        cur_first       = SYNC_FIRST_RST;
        cur_second      = SYNC_SECOND_RST;
        quiet           = 1'b0;
        holds_requested = 0;
        holds_served    = 0;
        framed_bytes    = 0;
        settings_used   = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < OPENING_LEN; i++) begin
            send_byte(OPENING[(OPENING_LEN - 1 - i) * BYTE_W +: BYTE_W]);
        end
        random_traffic(60);

        settle();
        set_syncs(8'h00, 8'hFF, 1'b0, CFG_UNUSED_TOP);
        // hold results off while a long frame keeps coming
        holds_requested++;
        send_frame(16'(MAX_LEN), 1'b0, 0);
        random_traffic(200);

        settle();
        set_syncs(8'hFF, 8'h00, 1'b1, CFG_UNUSED_TOP);
        random_traffic(200);

        settle();
        v = BYTE_W'($urandom_range(0, 255));
        set_syncs(v, v, 1'b0, CFG_UNUSED_TOP);
        random_traffic(60);

        settle();
        set_syncs(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)), 1'b1,
                  CFG_IDX_W'($urandom_range(CFG_SYNC_SECOND + 1, CFG_UNUSED_TOP)));
        random_traffic(200);

        settle();
        set_syncs(SYNC_FIRST_RST, SYNC_SECOND_RST, 1'b0, CFG_UNUSED_TOP);
        quiet = 1'b1;
        random_traffic(150);

        settle();
        $display("covered %0d bytes under %0d sync settings, %0d long result hold-offs",
                 bytes_in, settings_used, holds_served);
        $display("checked %0d payload beats, %0d frame ends, %0d length errors",
                 payload_beats, frame_ends, len_errors);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule : tb_top
